### sv/rmslm_pkg.sv
// Shared types and constants of the windowed RMS level meter.
package rmslm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SQUARE_W = 31;
   localparam int LEVEL_W = 17;
   localparam int WCOUNT_W = 9;
   localparam int FSCALE_W = 16;
   localparam int DIVISOR_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;
   localparam logic [FSCALE_W-1:0] FULL_SCALE_RESET = 16'd10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_of_data;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [WCOUNT_W-1:0] window_count;
   } rsp_word_type;

   typedef enum logic {
      MODE_DIV  = 1'b0,
      MODE_SQRT = 1'b1
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

### sv/rmslm_divsqrt.sv
// Shared restoring divide and square root unit, one compare-subtract step per cycle.
module rmslm_divsqrt #(
   parameter int W = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rmslm_pkg::unit_cmd_type               cmd,
   input  logic [W-1:0]                          operand,
   input  logic [rmslm_pkg::DIVISOR_W-1:0]       divisor,
   output rmslm_pkg::unit_stat_type              stat,
   output logic [W-1:0]                          result
);

   localparam int RW = W / 2 + 3;
   localparam int SW = $clog2(W + 1);

   rmslm_pkg::unit_mode_type            mode_ff;
   logic [W-1:0]                        opnd_ff, opnd_in;
   logic [RW-1:0]                       rem_ff, rem_in;
   logic [W-1:0]                        quo_ff, quo_in;
   logic [rmslm_pkg::DIVISOR_W-1:0]     divisor_ff;
   logic [SW-1:0]                       step_ff;
   logic                                done_ff;

   logic [RW-1:0] shifted;
   logic [RW-1:0] trial;
   logic [RW-1:0] diff;
   logic          ge;

   // Division brings down one dividend bit per step; the square root brings
   // down two and tries the partial root with 01 appended.
   always_comb begin
      unique case (mode_ff)
         rmslm_pkg::MODE_DIV: begin
            shifted = {rem_ff[RW-2:0], opnd_ff[W-1]};
            trial   = RW'(divisor_ff);
            opnd_in = {opnd_ff[W-2:0], 1'b0};
         end
         rmslm_pkg::MODE_SQRT: begin
            shifted = {rem_ff[RW-3:0], opnd_ff[W-1:W-2]};
            trial   = {quo_ff[RW-3:0], 2'b01};
            opnd_in = {opnd_ff[W-3:0], 2'b00};
         end
      endcase
      diff   = shifted - trial;
      ge     = (shifted >= trial);
      rem_in = ge ? diff : shifted;
      quo_in = {quo_ff[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            step_ff <= (cmd.mode == rmslm_pkg::MODE_DIV) ? SW'(W) : SW'(W / 2);
         end else if (step_ff != '0) begin
            step_ff <= step_ff - SW'(1);
            done_ff <= (step_ff == SW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff    <= cmd.mode;
         opnd_ff    <= operand;
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= '0;
      end else if (step_ff != '0) begin
         opnd_ff <= opnd_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
      end
   end

   assign stat.busy = (step_ff != '0);
   assign stat.done = done_ff;
   assign result    = quo_ff;

endmodule

### sv/windowed_rms_level_meter_core.sv
// Top level of the windowed RMS level meter: accumulation, sequencer and result register.
//
// The meter takes signed 16-bit PCM words, adds each square to a running sum and
// counts them. A window closes after WINDOW words, or early on a word marked end of
// data, which belongs to the closing window. For each closed window one result word
// carries level = min(65536, floor(floor(sqrt(floor(sum/count))) * 65536 / full_scale))
// and the number of samples the window held; level reads 0 while active is 0. A sample
// that does not close a window has its square registered at acceptance, and the sum and
// count are updated in the next cycle. For a closing sample, with W the even sum width
// (at least 32; 40 for a window of 256), a single restoring compare-subtract unit does
// the mean division and the scaling division at one bit per cycle over W steps each and
// the square root at one bit pair per cycle, and each phase reports done from a register
// after its last step; the result then waits until the output register is free. The
// request side is not ready during that work. The result sits in an output register, so
// the next window's samples are taken while an earlier result waits.
// Registers are to be written through the plain csr port only while the meter is idle;
// the meter itself does not enforce this.
module windowed_rms_level_meter_core #(
   parameter int WINDOW = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  rmslm_pkg::req_word_type                 req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output rmslm_pkg::rsp_word_type                 rsp_word,
   input  logic                                    csr_we,
   input  logic [rmslm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rmslm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // The count must hold WINDOW itself; the sum holds WINDOW squares of 2^30.
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = 30 + CNT_W;
   localparam int SUM_EVEN_W = SUM_W + (SUM_W % 2);
   localparam int W = (SUM_EVEN_W > 32) ? SUM_EVEN_W : 32;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ACC   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_SQRT  = 6'b001000,
      ST_SCALE = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type                            state_ff, state_in;
   logic [rmslm_pkg::SQUARE_W-1:0]       sq_ff, sq_in;
   logic                                 eod_ff;
   logic [SUM_W-1:0]                     sum_ff;
   logic [CNT_W-1:0]                     cnt_ff;
   logic [rmslm_pkg::FSCALE_W-1:0]       full_scale_ff;
   logic                                 active_ff;
   logic                                 rsp_valid_ff;
   rmslm_pkg::rsp_word_type              rsp_word_ff, rsp_word_in;

   logic signed [31:0]                   product;
   logic [SUM_W-1:0]                     sum_total;
   logic [CNT_W-1:0]                     cnt_total;
   logic                                 window_close;
   logic                                 accept;
   logic                                 rsp_free;
   logic [rmslm_pkg::LEVEL_W-1:0]        level_in;

   rmslm_pkg::unit_cmd_type              unit_cmd;
   rmslm_pkg::unit_stat_type             unit_stat;
   logic [W-1:0]                         unit_operand;
   logic [rmslm_pkg::DIVISOR_W-1:0]      unit_divisor;
   logic [W-1:0]                         unit_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // The square of a 16-bit sample is never negative and fits in 31 bits.
   assign product = 32'(req_word.sample) * 32'(req_word.sample);
   assign sq_in   = product[rmslm_pkg::SQUARE_W-1:0];

   assign sum_total    = sum_ff + SUM_W'(sq_ff);
   assign cnt_total    = cnt_ff + CNT_W'(1);
   assign window_close = (cnt_total == CNT_W'(WINDOW)) || eod_ff;

   // Level from the scaling quotient; a zero full scale counts as an endlessly
   // small divisor and saturates, and an inactive meter reports zero.
   always_comb begin
      priority if (!active_ff) begin
         level_in = '0;
      end else if (full_scale_ff == '0) begin
         level_in = rmslm_pkg::LEVEL_ONE;
      end else if (unit_result > W'(rmslm_pkg::LEVEL_ONE)) begin
         level_in = rmslm_pkg::LEVEL_ONE;
      end else begin
         level_in = unit_result[rmslm_pkg::LEVEL_W-1:0];
      end
      rsp_word_in.level        = level_in;
      rsp_word_in.window_count = rmslm_pkg::WCOUNT_W'(cnt_ff);
   end

   // Sequencer: each arithmetic phase starts the shared unit on the cycle the
   // previous one reports done, so the result register of the unit feeds the
   // next phase directly.
   always_comb begin
      state_in      = state_ff;
      unit_cmd      = '{start: 1'b0, mode: rmslm_pkg::MODE_DIV};
      unit_operand  = W'(sum_total);
      unit_divisor  = rmslm_pkg::DIVISOR_W'(cnt_total);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (window_close) begin
               unit_cmd = '{start: 1'b1, mode: rmslm_pkg::MODE_DIV};
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            unit_operand = unit_result;
            if (unit_stat.done) begin
               unit_cmd = '{start: 1'b1, mode: rmslm_pkg::MODE_SQRT};
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // The root never exceeds 32768, so 16 bits carry it.
            unit_operand = W'({unit_result[15:0], 16'h0000});
            unit_divisor = full_scale_ff;
            if (unit_stat.done) begin
               unit_cmd = '{start: 1'b1, mode: rmslm_pkg::MODE_DIV};
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (unit_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   rmslm_divsqrt #(
      .W (W)
   ) u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .operand (unit_operand),
      .divisor (unit_divisor),
      .stat    (unit_stat),
      .result  (unit_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         full_scale_ff <= rmslm_pkg::FULL_SCALE_RESET;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               rmslm_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_wdata;
               rmslm_pkg::CSR_ACTIVE:     active_ff     <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_ACC) begin
            sum_ff <= sum_total;
            cnt_ff <= cnt_total;
         end
         if (state_ff == ST_FIN && rsp_free) begin
            sum_ff       <= '0;
            cnt_ff       <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sq_ff  <= sq_in;
         eod_ff <= req_word.end_of_data;
      end
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The open window never holds more than WINDOW samples.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(WINDOW))
      else $error("sample count ran past the window length");

   // An emitted level never exceeds 1.0.
   a_level_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.level <= rmslm_pkg::LEVEL_ONE)
      else $error("level above full scale");

   // The shared unit is only started while it is not iterating.
   a_unit_start: assert property (@(posedge clock) disable iff (reset)
      unit_cmd.start |-> !unit_stat.busy)
      else $error("shared unit restarted while busy");

   // An accepted sample is always accumulated in the following cycle.
   a_accept_acc: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ACC)
      else $error("accepted sample was not accumulated");

endmodule
